@@ hdl/bdq_pkg.sv @@
// Shared constants and types for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 3;
  localparam int CAP_W         = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET   = 5'd16;
  localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the operation
    logic exec;    // update pointers, count and storage
    logic rd;      // read front and rear entries
    logic cfg_we;  // write the capacity register
  } bdq_cmd_t;

endpackage

@@ hdl/bdq_ctrl.sv @@
// Controller state machine for the bounded double-ended queue.
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cfg_valid,
  output logic              busy,
  output logic              cfg_ready,
  output logic              done,
  output bdq_pkg::bdq_cmd_t cmd
);
  import bdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC:  state_next = S_READ;
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign done       = (state == S_DONE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.rd     = (state == S_READ);
  assign cmd.cfg_we = (state == S_IDLE) && cfg_valid;

endmodule

@@ hdl/bdq_datapath.sv @@
// Datapath: ring storage, pointers, occupancy and result formation.
`timescale 1ns / 1ps

module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bdq_pkg::bdq_cmd_t           cmd,
  input  logic [bdq_pkg::KIND_W-1:0]  kind,
  input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
  input  logic [bdq_pkg::CAP_W-1:0]   cfg_data,
  output logic                        accepted,
  output logic signed [bdq_pkg::DATA_W-1:0] front_value,
  output logic signed [bdq_pkg::DATA_W-1:0] rear_value,
  output logic                        empty_flag,
  output logic                        full_flag
);
  import bdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Ring index that lies back steps before base; back is at most DEPTH.
  function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] back);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(DEPTH) - SUM_W'(back);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  logic [KIND_W-1:0] kind_q;
  logic [DATA_W-1:0] value_q;
  logic [CAP_W-1:0]  capacity;
  logic [PTR_W-1:0]  rear;
  logic [PTR_W-1:0]  rear_next;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  occ_next;
  logic              ok;
  logic              ok_next;
  logic [DATA_W-1:0] front_rd;
  logic [DATA_W-1:0] rear_rd;

  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  occ_ext;
  logic              can_push;
  logic              can_pop;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [PTR_W-1:0]  rear_inc;
  logic [PTR_W-1:0]  front_idx;

  assign cap_eff  = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
  assign occ_ext  = CMP_W'(occ);
  assign can_push = (occ_ext < cap_eff);
  assign can_pop  = (occ != '0);
  assign rear_inc = (rear == PTR_W'(DEPTH - 1)) ? '0 : rear + PTR_W'(1);

  always_comb begin
    rear_next = rear;
    occ_next  = occ;
    ok_next   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = rear;
    case (kind_q)
      KIND_PUSH_FRONT: begin
        if (can_push) begin
          wr_en    = 1'b1;
          wr_addr  = ring_back(rear, occ);
          occ_next = occ + CNT_W'(1);
          ok_next  = 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (can_push) begin
          if (can_pop) rear_next = rear_inc;
          wr_en    = 1'b1;
          wr_addr  = can_pop ? rear_inc : rear;
          occ_next = occ + CNT_W'(1);
          ok_next  = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (can_pop) begin
          occ_next = occ - CNT_W'(1);
          ok_next  = 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (can_pop) begin
          occ_next = occ - CNT_W'(1);
          if (occ != CNT_W'(1)) rear_next = ring_back(rear, CNT_W'(1));
          ok_next  = 1'b1;
        end
      end
      KIND_PEEK: ok_next = 1'b1;
      default:   ok_next = 1'b0;
    endcase
  end

  assign front_idx = can_pop ? ring_back(rear, occ - CNT_W'(1)) : rear;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      rear     <= '0;
      occ      <= '0;
    end else begin
      if (cmd.cfg_we) capacity <= cfg_data;
      if (cmd.exec) begin
        rear <= rear_next;
        occ  <= occ_next;
      end
    end
  end

  // Operation capture and status; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      value_q <= push_value;
    end
    if (cmd.exec) ok <= ok_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= value_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      front_rd <= mem[front_idx];
      rear_rd  <= mem[rear];
    end
  end

  assign accepted    = ok;
  assign empty_flag  = !can_pop;
  assign full_flag   = !can_push;
  assign front_value = can_pop ? front_rd : EMPTY_VALUE;
  assign rear_value  = can_pop ? rear_rd : EMPTY_VALUE;

endmodule

@@ hdl/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue: controller plus datapath.
`timescale 1ns / 1ps
// An operation is taken at the edge where start is high and busy is low; its
// result appears on the result ports, marked by done, once the controller has
// stepped through execute and storage read into result; the storage read port
// is registered. No new operation is taken until the controller is idle again.
// Reset (rst, synchronous, active high) empties the queue, sets capacity to 16
// and returns the controller to idle; results are not stalled by the receiver.

module bounded_double_ended_queue #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bdq_pkg::KIND_W-1:0]        kind,
  input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]         cfg_data,
  output logic                              done,
  output logic                              accepted,
  output logic signed [bdq_pkg::DATA_W-1:0] front_value,
  output logic signed [bdq_pkg::DATA_W-1:0] rear_value,
  output logic                              empty_flag,
  output logic                              full_flag
);
  import bdq_pkg::*;

  // Command bundle: capture, execute, read and capacity write strobes.
  bdq_cmd_t cmd;

  // Sequence each operation; cfg transfers are taken only while idle.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done),
    .cmd       (cmd)
  );

  // Hold the ring, its rear pointer and occupancy; drop -1 onto the value
  // ports whenever the queue is empty after the operation.
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .kind        (kind),
    .push_value  (push_value),
    .cfg_data    (cfg_data),
    .accepted    (accepted),
    .front_value (front_value),
    .rear_value  (rear_value),
    .empty_flag  (empty_flag),
    .full_flag   (full_flag)
  );

endmodule

@@ verif/bdq_checker.sv @@
// Checker for the bounded double-ended queue: predicts each operation and compares results.
`timescale 1ns / 1ps

module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [bdq_pkg::KIND_W-1:0]        kind,
  input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              done,
  input  logic                              accepted,
  input  logic signed [bdq_pkg::DATA_W-1:0] front_value,
  input  logic signed [bdq_pkg::DATA_W-1:0] rear_value,
  input  logic                              empty_flag,
  input  logic                              full_flag,
  output int                                mismatches,
  output int                                outstanding,
  output int                                compared
);
  import bdq_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] tail;
    logic                     is_empty;
    logic                     is_full;
  } deque_result_t;

  // Shadow deque: ring of DEPTH entries addressed back from the rear slot.
  logic signed [DATA_W-1:0] ring [DEPTH];
  int                       rear_slot;
  int                       held;
  logic [CAP_W-1:0]         capacity;

  deque_result_t pending_results [$];

  // Slot that lies steps entries behind the rear slot.
  function automatic int slot_behind(int steps);
    return (rear_slot + DEPTH - steps) % DEPTH;
  endfunction

  // Apply one operation to the shadow deque and return what the block should report.
  function automatic deque_result_t apply_op(input logic [KIND_W-1:0] op,
                                             input logic signed [DATA_W-1:0] value);
    deque_result_t r;
    int            limit;
    limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
    r.ok = 1'b0;
    case (op)
      KIND_PUSH_FRONT: begin
        if (held < limit) begin
          ring[slot_behind(held)] = value;
          held++;
          r.ok = 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (held < limit) begin
          if (held > 0) rear_slot = (rear_slot + 1) % DEPTH;
          ring[rear_slot] = value;
          held++;
          r.ok = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (held > 0) begin
          held--;
          r.ok = 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (held > 0) begin
          held--;
          if (held > 0) rear_slot = slot_behind(1);
          r.ok = 1'b1;
        end
      end
      KIND_PEEK: r.ok = 1'b1;
      default:   r.ok = 1'b0;
    endcase
    if (held == 0) begin
      r.head = EMPTY_VALUE;
      r.tail = EMPTY_VALUE;
    end else begin
      r.head = ring[slot_behind(held - 1)];
      r.tail = ring[rear_slot];
    end
    r.is_empty = (held == 0);
    r.is_full  = (held >= limit);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input deque_result_t want,
                                 input deque_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
               $time, what, want.ok, want.head, want.tail, want.is_empty, want.is_full);
      $display("           got      ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
               got.ok, got.head, got.tail, got.is_empty, got.is_full);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      rear_slot   = 0;
      held        = 0;
      capacity    = CAP_RESET;
      mismatches  = 0;
      compared    = 0;
      pending_results.delete();
    end else begin
      if (done) begin
        got = {accepted, front_value, rear_value, empty_flag, full_flag};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no operation outstanding", '0, got);
        end else begin
          want = pending_results.pop_front();
          compared++;
          if (got.ok !== want.ok || got.head !== want.head || got.tail !== want.tail ||
              got.is_empty !== want.is_empty || got.is_full !== want.is_full)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (start && !busy) pending_results.push_back(apply_op(kind, push_value));
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ verif/tb_bounded_double_ended_queue.sv @@
// Testbench top for the bounded double-ended queue: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;
  import bdq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT  = 200000;
  // Idle margin after the last result is back, before touching the capacity.
  localparam int SETTLE_CYCLES = 8;

  // Kinds the block must refuse without changing anything.
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

  typedef enum int {MIX_ANY, MIX_FILL, MIX_DRAIN} op_mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        kind = KIND_PEEK;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_data = CAP_RESET;
  logic                     done;
  logic                     accepted;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     empty_flag;
  logic                     full_flag;

  int mismatches;
  int outstanding;
  int compared;
  int ops_sent = 0;
  int cap_writes = 0;
  int cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  bounded_double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .kind(kind), .push_value(push_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .accepted(accepted),
    .front_value(front_value), .rear_value(rear_value),
    .empty_flag(empty_flag), .full_flag(full_flag)
  );

  bdq_checker #(.DEPTH(DEPTH)) deque_check (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .kind(kind), .push_value(push_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .accepted(accepted),
    .front_value(front_value), .rear_value(rear_value),
    .empty_flag(empty_flag), .full_flag(full_flag),
    .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_bounded_double_ended_queue: errors");
      $finish;
    end
  end

  // Present one operation and hold it until the block takes the transfer.
  // Leave start high on return so a following call runs back to back.
  task automatic send_op(input logic [KIND_W-1:0] op, input logic signed [DATA_W-1:0] value);
    start      <= 1'b1;
    kind       <= op;
    push_value <= value;
    do @(posedge clk); while (busy);
    ops_sent++;
  endtask

  // Drop start and idle for a number of cycles.
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every predicted result has come back, then let the block settle.
  task automatic wait_quiet();
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register; call only while the block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input op_mix_t mix);
    int roll;
    int push_share;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  push_share = 70;
      MIX_DRAIN: push_share = 25;
      default:   push_share = 45;
    endcase
    // Mostly real operations; a few peeks and refused kinds as noise.
    if (roll < 5) return KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
    if (roll < 13) return KIND_PEEK;
    if (roll < 13 + push_share) return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
    return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return '0;
      3:       return EMPTY_VALUE;  // a stored -1 must not read as empty
      default: return $urandom;
    endcase
  endfunction

  // Random operations in bursts with random gaps; hold start across a burst.
  task automatic run_phase(input int n, input op_mix_t mix);
    int      left;
    int      burst;
    op_mix_t burst_mix;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      // In a mixed phase swing between filling and draining so both ends get hit.
      burst_mix = (mix == MIX_ANY) ? op_mix_t'($urandom_range(0, 2)) : mix;
      repeat (burst) send_op(pick_kind(burst_mix), pick_value());
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-queue refusals, refused kinds, extremes at both ends,
    // stored -1, draining back to empty, all at the reset capacity.
    send_op(KIND_PEEK, '0);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_REAR, '0);
    send_op(KIND_RSVD_FIRST, MOST_POSITIVE);
    send_op(KIND_RSVD_MID, '0);
    send_op(KIND_RSVD_LAST, MOST_NEGATIVE);
    send_op(KIND_PUSH_FRONT, MOST_NEGATIVE);
    send_op(KIND_PUSH_REAR, MOST_POSITIVE);
    send_op(KIND_PEEK, '0);
    pause(2);
    send_op(KIND_PUSH_FRONT, '0);
    send_op(KIND_PUSH_REAR, EMPTY_VALUE);
    send_op(KIND_RSVD_MID, 32'sh1234_5678);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_REAR, '0);
    send_op(KIND_POP_REAR, '0);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_PUSH_REAR, 32'sh5555_5555);
    send_op(KIND_PUSH_FRONT, 32'shAAAA_AAAA);
    send_op(KIND_POP_REAR, '0);
    pause(1);

    // Capacity one: second push refused while full.
    set_capacity(5'd1);
    send_op(KIND_PUSH_FRONT, 32'sh0F0F_0F0F);
    send_op(KIND_PUSH_REAR, 32'shF0F0_F0F0);
    run_phase(50, MIX_ANY);

    // Capacity zero: every push refused, queue reports full, and empty as well once drained.
    set_capacity(5'd0);
    send_op(KIND_PUSH_REAR, MOST_POSITIVE);
    send_op(KIND_PEEK, '0);
    run_phase(30, MIX_ANY);

    // Above the ring size: saturate to DEPTH, fill all the way.
    set_capacity(5'd31);
    run_phase(60, MIX_FILL);
    set_capacity(5'd17);
    run_phase(60, MIX_ANY);

    // Fill at full size, then drop the capacity under the occupancy.
    set_capacity(5'd16);
    run_phase(40, MIX_FILL);
    set_capacity(5'd3);
    run_phase(60, MIX_ANY);

    repeat (4) begin
      set_capacity(CAP_W'($urandom_range(0, 31)));
      run_phase(40, MIX_ANY);
    end

    wait_quiet();
    $display("summary: %0d operations sent, %0d results checked, %0d capacity writes",
             ops_sent, compared, cap_writes);
    $display("summary: capacities 0, 1, 3, 16, 17, 31 and random, incl. lowering below fill");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_bounded_double_ended_queue: clean");
    end else begin
      $display("tb_bounded_double_ended_queue: errors");
    end
    $finish;
  end

endmodule
